// ===== rtl/core/ffba_pkg.sv =====
// Shared constants, descriptor type and sequencer states for the block allocator.
package ffba_pkg;

    localparam int HEADER_BYTES = 40;
    localparam int MAX_ENTRIES  = 64;
    localparam int ARENA_BYTES  = 65536;
    localparam int SMALL_GROWTH = 1024;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [16:0] HDR17       = 17'(HEADER_BYTES);
    localparam logic [16:0] GROWTH_MIN  = 17'(2 * HEADER_BYTES);
    localparam logic [16:0] GROWTH_FLR  = (2 * HEADER_BYTES > SMALL_GROWTH) ?
                                          17'(2 * HEADER_BYTES) : 17'(SMALL_GROWTH);
    localparam logic [16:0] GROWTH_RST  = 17'd4096;

    // Action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_RESIZE  = 2'd2;
    localparam logic [1:0] ACT_RELEASE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Register index
    localparam logic REG_GROWTH = 1'b0;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] used;
        logic [16:0] capacity;
        logic        is_free;
    } entry_t;

    typedef enum logic [1:0] {
        FP_FREE,
        FP_RESIZE,
        FP_REFREE
    } find_purpose_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FREE_WR,
        S_UP_RD,
        S_UP_CHK,
        S_DN_RD,
        S_DN_CHK,
        S_RM_RD,
        S_RM_WR,
        S_RSZ,
        S_AL_RD,
        S_AL_CHK,
        S_SH_RD,
        S_SH_WR,
        S_SPL_NEW,
        S_SPL_OLD,
        S_APPEND,
        S_AL_OK,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// A table walk reads each descriptor from the descriptor memory and then compares it,
// and a split, merge or resize-move adds one read and one write per descriptor shifted.
// Append waits for the remainder unit, which runs alongside the walk. One item at a time;
// in_ready is high only in the idle state. Reset clears the entry count, arena top and
// handshake state, sets growth_size to 4096; descriptor memory is not cleared and needs
// no clearing pass.
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] data_address,
    output logic [1:0]  status,
    output logic [16:0] arena_top,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t        state_reg, state_next;
    find_purpose_t purp_reg, purp_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   addr_reg, addr_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]   hw_reg, hw_next;
    logic [16:0]   gs_reg;
    entry_t        cur_reg, cur_next;
    logic          move_reg, move_next;
    logic [15:0]   granted_reg, granted_next;
    state_t        ret_reg, ret_next;
    logic [15:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          ov_reg, ov_next;
    logic [15:0]   od_reg, od_next;
    logic [1:0]    os_reg, os_next;
    logic [16:0]   ot_reg, ot_next;

    // memory and remainder unit hookup
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    entry_t           mem_wdata, rd;
    logic             div_start, div_busy;
    logic [16:0]      div_rem, size40;
    logic [18:0]      grow;
    logic [17:0]      spare, need;
    logic [16:0]      merged_cap;
    logic [15:0]      split_off;
    logic             cfg_wr;
    logic [16:0]      cfg_val;

    ffba_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    assign size40 = 17'({1'b0, size_reg} + HDR17);

    ffba_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (size40),
        .divisor   (gs_reg),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // grow = g * (floor(s/g) + 1) = s - (s mod g) + g
    assign grow       = 19'({2'b0, size40} - {2'b0, div_rem} + {2'b0, gs_reg});
    assign spare      = 18'({1'b0, rd.capacity} - {2'b0, rd.used});
    assign need       = 18'({1'b0, size40});
    assign merged_cap = 17'(rd.capacity + cur_reg.capacity + HDR17);
    assign split_off  = 16'(cur_reg.offset + cur_reg.used + 16'(HEADER_BYTES));

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_GROWTH);
    assign cfg_val = pwdata[16:0];
    assign prdata  = (paddr[2] == REG_GROWTH) ? {15'd0, gs_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= GROWTH_RST;
        end
        else if (cfg_wr && (cfg_val != 17'd0))
        begin
            gs_reg <= (cfg_val < GROWTH_MIN) ? GROWTH_FLR : cfg_val;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign data_address = od_reg;
    assign status       = os_reg;
    assign arena_top    = ot_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        purp_next     = purp_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        hw_next       = hw_reg;
        cur_next      = cur_reg;
        move_next     = move_reg;
        granted_next  = granted_reg;
        ret_next      = ret_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        od_next       = od_reg;
        os_next       = os_reg;
        ot_next       = ot_reg;
        mem_we        = 1'b0;
        mem_waddr     = k_reg;
        mem_wdata     = cur_reg;
        mem_raddr     = i_reg[IDX_W-1:0];
        div_start     = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next     = request_size;
                    addr_next     = block_address;
                    res_addr_next = 16'd0;
                    res_st_next   = ST_OK;
                    move_next     = 1'b0;
                    i_next        = '0;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (request_size == 16'd0)
                            begin
                                res_st_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_AL_RD;
                            end
                        end
                        ACT_FREE:
                        begin
                            purp_next  = FP_FREE;
                            state_next = S_FIND_RD;
                        end
                        ACT_RESIZE:
                        begin
                            if (request_size == 16'd0)
                            begin
                                res_st_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                            else if (block_address == 16'd0)
                            begin
                                state_next = S_AL_RD;
                            end
                            else
                            begin
                                purp_next  = FP_RESIZE;
                                state_next = S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            cnt_next   = '0;
                            hw_next    = 17'd0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // look up a descriptor by data address
            S_FIND_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    if (purp_reg == FP_REFREE)
                    begin
                        res_addr_next = granted_reg;
                    end
                    else
                    begin
                        res_st_next = ST_UNKNOWN;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end

            S_FIND_CHK:
            begin
                if (16'(rd.offset + 16'(HEADER_BYTES)) == addr_reg)
                begin
                    k_next   = i_reg[IDX_W-1:0];
                    cur_next = rd;
                    case (purp_reg)
                        FP_RESIZE: state_next = S_RSZ;
                        default:   state_next = S_FREE_WR;
                    endcase
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            // mark free, then merge with neighbors
            S_FREE_WR:
            begin
                cur_next.used    = 16'd0;
                cur_next.is_free = 1'b1;
                mem_we           = 1'b1;
                mem_wdata        = cur_next;
                state_next       = S_UP_RD;
            end

            S_UP_RD:
            begin
                mem_raddr = IDX_W'(k_reg + 1'b1);
                if ({1'b0, k_reg} + 1'b1 < cnt_reg)
                begin
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_UP_CHK:
            begin
                if (rd.is_free)
                begin
                    cur_next.capacity = merged_cap;
                    mem_we            = 1'b1;
                    mem_wdata         = cur_next;
                    j_next            = {1'b0, k_reg} + 1'b1;
                    ret_next          = S_DN_RD;
                    state_next        = S_RM_RD;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD:
            begin
                mem_raddr = k_reg - 1'b1;
                if (k_reg != '0)
                begin
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_CHK:
            begin
                if (rd.is_free)
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = k_reg - 1'b1;
                    mem_wdata          = rd;
                    mem_wdata.capacity = merged_cap;
                    j_next             = {1'b0, k_reg};
                    ret_next           = S_DONE;
                    state_next         = S_RM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // remove entry j by shifting the rest down
            S_RM_RD:
            begin
                mem_raddr = IDX_W'(j_reg + 1'b1);
                if (j_reg + 1'b1 < cnt_reg)
                begin
                    state_next = S_RM_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ret_reg;
                end
            end

            S_RM_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg[IDX_W-1:0];
                mem_wdata  = rd;
                j_next     = j_reg + 1'b1;
                state_next = S_RM_RD;
            end

            // resize: in place or move
            S_RSZ:
            begin
                if ({1'b0, size_reg} <= cur_reg.capacity)
                begin
                    cur_next.used = size_reg;
                    mem_we        = 1'b1;
                    mem_wdata     = cur_next;
                    res_addr_next = addr_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    move_next  = 1'b1;
                    i_next     = '0;
                    state_next = S_AL_RD;
                end
            end

            // first-fit walk; remainder unit starts on entry
            S_AL_RD:
            begin
                if (i_reg == '0)
                begin
                    div_start = 1'b1;
                end
                if (i_reg == cnt_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_AL_CHK;
                end
            end

            S_AL_CHK:
            begin
                if (rd.is_free && (rd.capacity >= {1'b0, size_reg}))
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = i_reg[IDX_W-1:0];
                    mem_wdata      = rd;
                    mem_wdata.is_free = 1'b0;
                    mem_wdata.used = size_reg;
                    res_addr_next  = 16'(rd.offset + 16'(HEADER_BYTES));
                    state_next     = S_AL_OK;
                end
                else if (!rd.is_free && (cnt_reg < CNT_W'(MAX_ENTRIES)) && (spare >= need))
                begin
                    cur_next   = rd;
                    k_next     = i_reg[IDX_W-1:0];
                    j_next     = cnt_reg;
                    state_next = S_SH_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_AL_RD;
                end
            end

            // open a slot above k by shifting entries up
            S_SH_RD:
            begin
                mem_raddr = IDX_W'(j_reg - 1'b1);
                if (j_reg > {1'b0, k_reg} + 1'b1)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_SPL_NEW;
                end
            end

            S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg[IDX_W-1:0];
                mem_wdata  = rd;
                j_next     = j_reg - 1'b1;
                state_next = S_SH_RD;
            end

            S_SPL_NEW:
            begin
                mem_we             = 1'b1;
                mem_waddr          = k_reg + 1'b1;
                mem_wdata.offset   = split_off;
                mem_wdata.used     = size_reg;
                mem_wdata.capacity = 17'(cur_reg.capacity - {1'b0, cur_reg.used} - HDR17);
                mem_wdata.is_free  = 1'b0;
                res_addr_next      = 16'(split_off + 16'(HEADER_BYTES));
                state_next         = S_SPL_OLD;
            end

            S_SPL_OLD:
            begin
                mem_we             = 1'b1;
                mem_wdata.capacity = {1'b0, cur_reg.used};
                cnt_next           = cnt_reg + 1'b1;
                state_next         = S_AL_OK;
            end

            // grow the arena at the top
            S_APPEND:
            begin
                if (!div_busy)
                begin
                    if ((cnt_reg >= CNT_W'(MAX_ENTRIES)) ||
                        (20'({3'b0, hw_reg}) + 20'(grow) > 20'(ARENA_BYTES)))
                    begin
                        res_addr_next = 16'd0;
                        res_st_next   = ST_FULL;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = cnt_reg[IDX_W-1:0];
                        mem_wdata.offset   = hw_reg[15:0];
                        mem_wdata.used     = size_reg;
                        mem_wdata.capacity = 17'(grow - 19'(HEADER_BYTES));
                        mem_wdata.is_free  = 1'b0;
                        cnt_next           = cnt_reg + 1'b1;
                        hw_next            = 17'({2'b0, hw_reg} + grow);
                        res_addr_next      = 16'(hw_reg[15:0] + 16'(HEADER_BYTES));
                        state_next         = S_AL_OK;
                    end
                end
            end

            S_AL_OK:
            begin
                if (move_reg)
                begin
                    granted_next = res_addr_reg;
                    purp_next    = FP_REFREE;
                    i_next       = '0;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    od_next    = res_addr_reg;
                    os_next    = res_st_reg;
                    ot_next    = hw_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            hw_reg    <= 17'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hw_reg    <= hw_next;
            ov_reg    <= ov_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        purp_reg     <= purp_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        move_reg     <= move_next;
        granted_reg  <= granted_next;
        ret_reg      <= ret_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        od_reg       <= od_next;
        os_reg       <= os_next;
        ot_reg       <= ot_next;
    end

endmodule

// ===== rtl/core/ffba_ram.sv =====
// Descriptor table memory: one write port, one registered read port.
module ffba_ram
    import ffba_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [MAX_ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ffba_rem.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module ffba_rem
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [16:0] remainder
);

    logic [16:0] rem_reg, rem_next;
    logic [16:0] dvd_reg, dvd_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [17:0] trial;

    assign trial     = {rem_reg, dvd_reg[16]};
    assign busy      = (cnt_reg != 5'd0);
    assign remainder = rem_reg;

    // One shift-subtract step per cycle
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = 17'd0;
            dvd_next = dividend;
            cnt_next = 5'd17;
        end
        else if (busy)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = 17'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[16:0];
            end
            dvd_next = {dvd_reg[15:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

endmodule

// ===== rtl/core/ffba_checker.sv =====
// Port-level checks for the block allocator, bound to the top level.
module ffba_checker
    import ffba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] data_address,
    input logic [1:0]  status,
    input logic [16:0] arena_top
);

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second item while busy");

    // failures grant nothing
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (data_address == 16'd0))
        else $error("address granted on failure");

    // arena never passes its size
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (arena_top <= 17'(ARENA_BYTES)))
        else $error("arena top beyond arena");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_address) &&
                                       $stable(status) && $stable(arena_top)))
        else $error("result changed while stalled");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_address (data_address),
    .status       (status),
    .arena_top    (arena_top)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block allocator core.
module testbench
    import ffba_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [15:0] addr;
        logic [1:0]  st;
        logic [16:0] top;
    } grant_t;

    // Scoreboard: tracks the descriptor table and queues the expected grants
    class alloc_scoreboard;
        int unsigned offs[MAX_ENTRIES];
        int unsigned used[MAX_ENTRIES];
        int unsigned cap[MAX_ENTRIES];
        bit          free_m[MAX_ENTRIES];
        int unsigned count;
        int unsigned top;
        int unsigned growth;
        grant_t      pending_grants[$];
        int          errors;

        function new();
            count  = 0;
            top    = 0;
            growth = 4096;
            errors = 0;
        endfunction

        function void write_growth(int unsigned v);
            v &= 32'h1FFFF;
            if (v == 0)
                return;
            if (v < 2 * HEADER_BYTES)
                v = GROWTH_FLR;
            growth = v;
        endfunction

        function int lookup(int unsigned a);
            for (int i = 0; i < count; i++)
                if (((offs[i] + HEADER_BYTES) & 32'hFFFF) == a)
                    return i;
            return -1;
        endfunction

        function void drop(int unsigned i);
            for (; i + 1 < count; i++)
            begin
                offs[i]   = offs[i+1];
                used[i]   = used[i+1];
                cap[i]    = cap[i+1];
                free_m[i] = free_m[i+1];
            end
            count--;
        endfunction

        function void release_block(int unsigned i);
            free_m[i] = 1;
            used[i]   = 0;
            if (i + 1 < count && free_m[i+1])
            begin
                cap[i] += cap[i+1] + HEADER_BYTES;
                drop(i + 1);
            end
            if (i > 0 && free_m[i-1])
            begin
                cap[i-1] += cap[i] + HEADER_BYTES;
                drop(i);
            end
        endfunction

        // First fit: reuse a free block, split a used tail, or append
        function logic [1:0] carve(int unsigned size, output int unsigned a);
            longint unsigned grow;
            grow = longint'(growth) * ((longint'(size) + HEADER_BYTES) / growth + 1);
            a = 0;
            for (int i = 0; i < count; i++)
            begin
                if (free_m[i] && cap[i] >= size)
                begin
                    free_m[i] = 0;
                    used[i]   = size;
                    a = offs[i] + HEADER_BYTES;
                    return ST_OK;
                end
                if (!free_m[i] && count < MAX_ENTRIES &&
                    longint'(cap[i]) - longint'(used[i]) >= longint'(size) + HEADER_BYTES)
                begin
                    for (int j = count; j > i + 1; j--)
                    begin
                        offs[j]   = offs[j-1];
                        used[j]   = used[j-1];
                        cap[j]    = cap[j-1];
                        free_m[j] = free_m[j-1];
                    end
                    offs[i+1]   = offs[i] + used[i] + HEADER_BYTES;
                    cap[i+1]    = cap[i] - used[i] - HEADER_BYTES;
                    used[i+1]   = size;
                    free_m[i+1] = 0;
                    cap[i]      = used[i];
                    count++;
                    a = offs[i+1] + HEADER_BYTES;
                    return ST_OK;
                end
            end
            if (count >= MAX_ENTRIES || longint'(top) + grow > ARENA_BYTES)
                return ST_FULL;
            offs[count]   = top;
            used[count]   = size;
            cap[count]    = int'(grow) - HEADER_BYTES;
            free_m[count] = 0;
            count++;
            top += int'(grow);
            a = offs[count-1] + HEADER_BYTES;
            return ST_OK;
        endfunction

        function void note_item(logic [1:0] act, logic [15:0] size, logic [15:0] addr);
            int          k;
            int unsigned res;
            int unsigned moved;
            logic [1:0]  st;
            grant_t      g;
            res = 0;
            st  = ST_OK;
            case (act)
                ACT_ALLOC:
                    if (size == 0) st = ST_ZERO;
                    else st = carve(size, res);
                ACT_FREE:
                begin
                    k = lookup(addr);
                    if (k < 0) st = ST_UNKNOWN;
                    else release_block(k);
                end
                ACT_RESIZE:
                begin
                    if (size == 0)
                        st = ST_ZERO;
                    else if (addr == 0)
                        st = carve(size, res);
                    else
                    begin
                        k = lookup(addr);
                        if (k < 0)
                            st = ST_UNKNOWN;
                        else if (size <= cap[k])
                        begin
                            used[k] = size;
                            res = addr;
                        end
                        else
                        begin
                            // move: old block freed only when the new one is granted
                            st = carve(size, moved);
                            if (st == ST_OK)
                            begin
                                k = lookup(addr);
                                if (k >= 0) release_block(k);
                                res = moved;
                            end
                        end
                    end
                end
                default:
                begin
                    count = 0;
                    top   = 0;
                end
            endcase
            g.addr = res[15:0];
            g.st   = st;
            g.top  = top[16:0];
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [15:0] addr, logic [1:0] st, logic [16:0] tp);
            grant_t g;
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result addr=%0d status=%0d top=%0d",
                         $time, addr, st, tp);
                errors++;
                return;
            end
            g = pending_grants.pop_front();
            if (addr !== g.addr)
            begin
                $display("%0t: data_address expected %0d actual %0d", $time, g.addr, addr);
                errors++;
            end
            if (st !== g.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, g.st, st);
                errors++;
            end
            if (tp !== g.top)
            begin
                $display("%0t: arena_top expected %0d actual %0d", $time, g.top, tp);
                errors++;
            end
        endfunction

        // data address of a random live descriptor, or any address when empty
        function logic [15:0] pick_live();
            if (count == 0)
                return 16'($urandom);
            return 16'(offs[$urandom_range(0, count - 1)] + HEADER_BYTES);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [15:0] request_size;
    logic [15:0] block_address;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] data_address;
    logic [1:0]  status;
    logic [16:0] arena_top;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    int              idle_cycles;

    first_fit_block_allocator_core u_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Send one request item with a random lead-in gap
    task automatic send(logic [1:0] act, logic [15:0] size, logic [15:0] addr);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action        = act;
        request_size  = size;
        block_address = addr;
        in_valid      = 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_item(act, size, addr);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_grants.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // APB write of growth_size, only while idle
    task automatic write_growth(logic [31:0] v);
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 3'(4 * REG_GROWTH);
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.write_growth(v);
    endtask

    function automatic logic [15:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(1, 300));
        if (r < 90) return 16'($urandom_range(1, 4000));
        if (r < 97) return 16'($urandom_range(4000, 20000));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_random();
        int          r;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : sb.pick_live();
        if (r < 45)
            send(ACT_ALLOC, rand_size(), 16'($urandom));
        else if (r < 70)
            send(ACT_FREE, 16'($urandom), a);
        else if (r < 92)
            send(ACT_RESIZE, rand_size(), ($urandom_range(0, 9) == 0) ? 16'd0 : a);
        else if (r < 94)
            send(ACT_RELEASE, 16'($urandom), 16'($urandom));
        else
            send(($urandom_range(0, 1) != 0) ? ACT_ALLOC : ACT_RESIZE, 16'd0, a);
    endtask

    // Result side: random back-pressure, check each accepted result
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(data_address, status, arena_top);
            @(negedge clk);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int unsigned settings[9] = '{1, 65536, 80, 0, 79, 200, 100000, 1024, 4096};
        sb            = new();
        idle_cycles   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_ALLOC;
        request_size  = '0;
        block_address = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero size, full arena, split, in-place and moving resize
        send(ACT_ALLOC, 16'd0, 16'd0);
        send(ACT_ALLOC, 16'hFFFF, 16'd0);
        send(ACT_ALLOC, 16'd100, 16'd0);
        send(ACT_FREE, 16'd0, 16'hFFFF);
        send(ACT_FREE, 16'd0, 16'd0);
        send(ACT_ALLOC, 16'd200, 16'd0);
        send(ACT_RESIZE, 16'd50, 16'd180);
        send(ACT_RESIZE, 16'd10, 16'd0);
        send(ACT_RESIZE, 16'd8000, 16'd180);
        send(ACT_RESIZE, 16'hFFFF, sb.pick_live());
        send(ACT_FREE, 16'd0, 16'd40);
        send(ACT_FREE, 16'd0, 16'd40);
        send(ACT_RESIZE, 16'd10, 16'd40);
        send(ACT_RESIZE, 16'd5, 16'h1234);
        send(ACT_RESIZE, 16'd0, 16'd40);
        send(ACT_RELEASE, 16'hFFFF, 16'hFFFF);
        send(ACT_ALLOC, 16'd1, 16'd0);
        send(ACT_RELEASE, 16'd0, 16'd0);

        // random phases over several growth settings
        foreach (settings[p])
        begin
            write_growth(settings[p]);
            if (p == 0)
            begin
                // fill the descriptor table with tiny blocks
                for (int i = 0; i < 70; i++)
                    send(ACT_ALLOC, 16'($urandom_range(1, 8)), 16'd0);
            end
            for (int i = 0; i < 110; i++)
                send_random();
        end

        drain();
        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/ffba_rem.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
tb/testbench.sv
